@@ design/hm5_pkg.sv @@
// ----------------------------------------------------------------------------
// HMAC-MD5 engine package
// Shared constants, state types and MD5 round tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hm5_pkg;

   localparam int MAX_KEY_BYTES     = 128;
   localparam int MAX_MESSAGE_BYTES = 128;
   localparam int BLOCK_BYTES       = 64;
   localparam int CSR_INDEX_W       = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_LOW  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_HIGH = 8'd1;

   localparam logic [7:0]   IPAD_BYTE      = 8'h36;
   localparam logic [7:0]   OPAD_BYTE      = 8'h5C;
   localparam logic [7:0]   PAD_MARK       = 8'h80;
   localparam logic [11:0]  OUTER_LEN_BITS = 12'd640;
   localparam logic [127:0] MD5_IV = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

   typedef enum logic [1:0] {
      PH_AWAIT_KEY,
      PH_KEY,
      PH_KEY_READY,
      PH_MSG
   } phase_type;

   typedef enum logic [2:0] {
      MODE_KEY_RAW,
      MODE_KEY_IPAD,
      MODE_KEY_OPAD,
      MODE_BUF,
      MODE_OUTER
   } mode_type;

   typedef enum logic [1:0] {
      DST_CHAIN,
      DST_OUTER,
      DST_RESULT
   } dst_type;

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_PREP,
      CORE_RUN
   } core_state_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_KEYSTART,
      ST_KEYBYTE,
      ST_KEYBUF,
      ST_CHECKLAST,
      ST_CLOSE,
      ST_FIN_A,
      ST_FIN_B,
      ST_FIN_DONE,
      ST_MSG,
      ST_MSGPH,
      ST_OPAD,
      ST_MSGWR,
      ST_MSGLAST,
      ST_OUTER,
      ST_EMIT,
      ST_WAIT
   } state_type;

   function automatic logic [31:0] md5_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] md5_shift(input logic [5:0] i);
      logic [4:0] s;
      case ({i[5:4], i[1:0]})
         4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
         4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
         default: s = 5'd7;
      endcase
      return s;
   endfunction

   // Message word used by round i.
   function automatic logic [3:0] md5_g(input logic [5:0] i);
      logic [3:0] g;
      case (i[5:4])
         2'd0:    g = i[3:0];
         2'd1:    g = 4'(i[3:0] * 4'd5 + 4'd1);
         2'd2:    g = 4'(i[3:0] * 4'd3 + 4'd5);
         default: g = 4'(i[3:0] * 4'd7);
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

@@ design/hm5_if.sv @@
// ----------------------------------------------------------------------------
// HMAC-MD5 channel interfaces
// Request, response and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hm5_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, req_type, data_byte, last_byte, input ready);
   modport sink   (input valid, req_type, data_byte, last_byte, output ready);
endinterface

interface hm5_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_half;
   logic        half_last;
   logic        match;
   modport source (output valid, digest_half, half_last, match, input ready);
   modport sink   (input valid, digest_half, half_last, match, output ready);
endinterface

interface hm5_csr_if;
   logic                            valid;
   logic                            ready;
   logic [hm5_pkg::CSR_INDEX_W-1:0] index;
   logic [63:0]                     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/hm5_mem.sv @@
// ----------------------------------------------------------------------------
// HMAC-MD5 block memory
// 32 x 32-bit words with byte writes: key block in the lower half, data block
// in the upper half. Key bytes carry valid bits so an unwritten byte reads 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hm5_mem (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        key_clear,
   input  wire logic        wr_en,
   input  wire logic [6:0]  wr_addr,
   input  wire logic [7:0]  wr_byte,
   input  wire logic [4:0]  rd_addr,
   output logic      [31:0] rd_data
);

   logic [31:0] mem [32];
   logic [63:0] kval_ff;
   logic [31:0] rd_ff;
   logic [3:0]  mask_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[6:2]][{wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
      end
      rd_ff   <= mem[rd_addr];
      mask_ff <= rd_addr[4] ? 4'hF : kval_ff[{rd_addr[3:0], 2'b00} +: 4];
   end

   always_ff @(posedge clock) begin
      if (reset || key_clear) begin
         kval_ff <= '0;
      end else if (wr_en && !wr_addr[6]) begin
         kval_ff[wr_addr[5:0]] <= 1'b1;
      end
   end

   always_comb begin
      for (int b = 0; b < 4; b++) begin
         rd_data[b*8 +: 8] = mask_ff[b] ? rd_ff[b*8 +: 8] : 8'h00;
      end
   end

endmodule

`default_nettype wire

@@ design/hm5_core.sv @@
// ----------------------------------------------------------------------------
// MD5 compression core
// One round per cycle; each message word is read from memory in the cycle before its round.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hm5_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [127:0] init,
   input  wire logic [31:0]  word,
   output logic      [3:0]   rd_index,
   output logic              done,
   output logic      [127:0] digest
);

   hm5_pkg::core_state_type state_ff, state_in;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [127:0] h_ff, h_in;
   logic [5:0]   rnd_ff, rnd_in;
   logic         done_ff, done_in;
   logic [31:0]  f, t;
   logic [63:0]  rot;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hm5_pkg::CORE_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      h_ff   <= h_in;
      rnd_ff <= rnd_in;
   end

   always_comb begin
      case (rnd_ff[5:4])
         2'd0:    f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1:    f = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2:    f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      t   = a_ff + f + hm5_pkg::md5_k(rnd_ff) + word;
      rot = {t, t} << hm5_pkg::md5_shift(rnd_ff);
   end

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      h_in     = h_ff;
      rnd_in   = rnd_ff;
      done_in  = 1'b0;
      rd_index = hm5_pkg::md5_g(6'd0);
      case (state_ff)
         hm5_pkg::CORE_IDLE: begin
            if (start) begin
               a_in     = init[31:0];
               b_in     = init[63:32];
               c_in     = init[95:64];
               d_in     = init[127:96];
               h_in     = init;
               state_in = hm5_pkg::CORE_PREP;
            end
         end
         hm5_pkg::CORE_PREP: begin
            rnd_in   = 6'd0;
            state_in = hm5_pkg::CORE_RUN;
         end
         hm5_pkg::CORE_RUN: begin
            rd_index = hm5_pkg::md5_g(rnd_ff + 6'd1);
            a_in     = d_ff;
            d_in     = c_ff;
            c_in     = b_ff;
            b_in     = b_ff + rot[63:32];
            rnd_in   = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               done_in  = 1'b1;
               state_in = hm5_pkg::CORE_IDLE;
            end
         end
         default: state_in = hm5_pkg::CORE_IDLE;
      endcase
   end

   assign done   = done_ff;
   assign digest = {h_ff[127:96] + d_ff, h_ff[95:64] + c_ff,
                    h_ff[63:32] + b_ff, h_ff[31:0] + a_ff};

endmodule

`default_nettype wire

@@ design/hmac_md5_engine.sv @@
// ----------------------------------------------------------------------------
// HMAC-MD5 engine
// Byte-serial HMAC-MD5 over 64-byte blocks with a compare against a target.
// ----------------------------------------------------------------------------
// Usage: key bytes (req_type 0) are sent first, last_byte closing the key;
// message bytes (req_type 1) follow, last_byte closing the message. After the
// final message byte two response transactions carry the digest, low half
// first, each flagged with whether the whole digest equals the target set
// through the register channel (index 0 low half, index 1 high half).
// Key and data blocks sit in one byte-writable word memory that the MD5 core
// reads one word per round. Each compression runs through start, prefetch,
// 64 rounds and done before the next control step. A message byte that
// completes a 64-byte block adds one compression, as do the 65th and 128th
// key bytes; the first message byte after a key adds two (inner and outer
// pad); the final message byte adds two or three (padding block(s) and outer
// hash). Closing a key longer than 64 bytes adds one or two compressions.
// One transaction is handled at a time. Reset clears the key (empty key),
// target registers, state, phase and the byte and response counters; no
// clearing pass is needed. A stalled response receiver does not block new
// requests until another digest is ready to be emitted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hmac_md5_engine #(
   parameter int MAX_KEY_BYTES     = hm5_pkg::MAX_KEY_BYTES,
   parameter int MAX_MESSAGE_BYTES = hm5_pkg::MAX_MESSAGE_BYTES
) (
   input  wire logic clock,
   input  wire logic reset,
   hm5_req_if.sink   req_ch,
   hm5_rsp_if.source rsp_ch,
   hm5_csr_if.sink   csr_ch
);

   hm5_pkg::state_type state_ff, state_in, ret_ff, ret_in, cret_ff, cret_in;
   hm5_pkg::phase_type phase_ff, phase_in;
   hm5_pkg::mode_type  mode_ff, mode_in;
   hm5_pkg::dst_type   dst_ff, dst_in;

   logic [7:0]   kc_ff, kc_in, mc_ff, mc_in;
   logic [127:0] chain_ff, chain_in, outer_ff, outer_in, kdig_ff, kdig_in;
   logic [127:0] rslt_ff, rslt_in;
   logic         hashed_ff, hashed_in;
   logic         last_ff, last_in;
   logic [7:0]   byte_ff, byte_in;
   logic [6:0]   rem_ff, rem_in;
   logic         put80_ff, put80_in, addlen_ff, addlen_in, fkey_ff, fkey_in;
   logic [11:0]  len_ff, len_in;
   logic [3:0]   j_ff;
   logic [63:0]  tlo_ff, thi_ff;
   logic [1:0]   cnt_ff, cnt_in;
   logic [63:0]  olo_ff, olo_in, ohi_ff, ohi_in;
   logic         omatch_ff, omatch_in;

   logic         job_start;
   logic [127:0] core_init;
   logic [3:0]   core_idx;
   logic         core_done;
   logic [127:0] core_digest;
   logic [31:0]  mem_rd, word, kw;
   logic         mem_we, key_clear;
   logic [6:0]   mem_waddr;
   logic [6:0]   pos;
   logic [8:0]   mlen;

   hm5_mem u_mem (
      .clock     (clock),
      .reset     (reset),
      .key_clear (key_clear),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_byte   (byte_ff),
      .rd_addr   ({mode_ff == hm5_pkg::MODE_BUF, core_idx}),
      .rd_data   (mem_rd)
   );

   hm5_core u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (job_start),
      .init     (core_init),
      .word     (word),
      .rd_index (core_idx),
      .done     (core_done),
      .digest   (core_digest)
   );

   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = (cnt_ff != 2'd0);
   assign rsp_ch.digest_half = (cnt_ff == 2'd2) ? olo_ff : ohi_ff;
   assign rsp_ch.half_last   = (cnt_ff == 2'd1);
   assign rsp_ch.match       = omatch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= hm5_pkg::ST_IDLE;
         phase_ff  <= hm5_pkg::PH_AWAIT_KEY;
         kc_ff     <= 8'd0;
         mc_ff     <= 8'd0;
         hashed_ff <= 1'b0;
         chain_ff  <= hm5_pkg::MD5_IV;
         cnt_ff    <= 2'd0;
         tlo_ff    <= 64'd0;
         thi_ff    <= 64'd0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         kc_ff     <= kc_in;
         mc_ff     <= mc_in;
         hashed_ff <= hashed_in;
         chain_ff  <= chain_in;
         cnt_ff    <= cnt_in;
         if (csr_ch.valid && csr_ch.index == hm5_pkg::CSR_TARGET_LOW) begin
            tlo_ff <= csr_ch.data;
         end
         if (csr_ch.valid && csr_ch.index == hm5_pkg::CSR_TARGET_HIGH) begin
            thi_ff <= csr_ch.data;
         end
      end
      ret_ff    <= ret_in;
      cret_ff   <= cret_in;
      mode_ff   <= mode_in;
      dst_ff    <= dst_in;
      outer_ff  <= outer_in;
      kdig_ff   <= kdig_in;
      rslt_ff   <= rslt_in;
      last_ff   <= last_in;
      byte_ff   <= byte_in;
      rem_ff    <= rem_in;
      put80_ff  <= put80_in;
      addlen_ff <= addlen_in;
      fkey_ff   <= fkey_in;
      len_ff    <= len_in;
      j_ff      <= core_idx;
      olo_ff    <= olo_in;
      ohi_ff    <= ohi_in;
      omatch_ff <= omatch_in;
   end

   // Message word presented to the core, built from the memory word read in the
   // previous cycle, hashed key or inner digest, plus padding, length, pad bytes.
   always_comb begin
      kw = mem_rd;
      if (hashed_ff) begin
         kw = (j_ff[3:2] == 2'd0) ? kdig_ff[{j_ff[1:0], 5'b00000} +: 32] : 32'd0;
      end
      word = 32'd0;
      pos  = 7'd0;
      case (mode_ff)
         hm5_pkg::MODE_KEY_RAW:  word = kw;
         hm5_pkg::MODE_KEY_IPAD: word = kw ^ {4{hm5_pkg::IPAD_BYTE}};
         hm5_pkg::MODE_KEY_OPAD: word = kw ^ {4{hm5_pkg::OPAD_BYTE}};
         hm5_pkg::MODE_BUF: begin
            for (int b = 0; b < 4; b++) begin
               pos = {1'b0, j_ff, 2'(b)};
               if (pos < rem_ff) begin
                  word[b*8 +: 8] = mem_rd[b*8 +: 8];
               end else if (pos == rem_ff && put80_ff) begin
                  word[b*8 +: 8] = hm5_pkg::PAD_MARK;
               end else begin
                  word[b*8 +: 8] = 8'h00;
               end
            end
            if (addlen_ff && j_ff == 4'd14) begin
               word = {20'd0, len_ff};
            end else if (addlen_ff && j_ff == 4'd15) begin
               word = 32'd0;
            end
         end
         hm5_pkg::MODE_OUTER: begin
            if (j_ff[3:2] == 2'd0) begin
               word = chain_ff[{j_ff[1:0], 5'b00000} +: 32];
            end else if (j_ff == 4'd4) begin
               word = {24'd0, hm5_pkg::PAD_MARK};
            end else if (j_ff == 4'd14) begin
               word = {20'd0, hm5_pkg::OUTER_LEN_BITS};
            end
         end
         default: word = 32'd0;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      ret_in    = ret_ff;
      cret_in   = cret_ff;
      mode_in   = mode_ff;
      dst_in    = dst_ff;
      kc_in     = kc_ff;
      mc_in     = mc_ff;
      chain_in  = chain_ff;
      outer_in  = outer_ff;
      kdig_in   = kdig_ff;
      rslt_in   = rslt_ff;
      hashed_in = hashed_ff;
      last_in   = last_ff;
      byte_in   = byte_ff;
      rem_in    = rem_ff;
      put80_in  = put80_ff;
      addlen_in = addlen_ff;
      fkey_in   = fkey_ff;
      len_in    = len_ff;
      olo_in    = olo_ff;
      ohi_in    = ohi_ff;
      omatch_in = omatch_ff;
      cnt_in    = cnt_ff;
      req_ch.ready = 1'b0;
      job_start = 1'b0;
      core_init = chain_ff;
      mem_we    = 1'b0;
      mem_waddr = 7'd0;
      key_clear = 1'b0;
      mlen      = {1'b0, mc_ff} + 9'd64;

      if (rsp_ch.valid && rsp_ch.ready) begin
         cnt_in = cnt_ff - 2'd1;
      end

      case (state_ff)
         hm5_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               byte_in  = req_ch.data_byte;
               last_in  = req_ch.last_byte;
               state_in = req_ch.req_type ? hm5_pkg::ST_MSG : hm5_pkg::ST_KEYSTART;
            end
         end
         hm5_pkg::ST_KEYSTART: begin
            if (phase_ff != hm5_pkg::PH_KEY) begin
               key_clear = 1'b1;
               kc_in     = 8'd0;
               chain_in  = hm5_pkg::MD5_IV;
               hashed_in = 1'b0;
               phase_in  = hm5_pkg::PH_KEY;
            end
            state_in = hm5_pkg::ST_KEYBYTE;
         end
         hm5_pkg::ST_KEYBYTE: begin
            state_in = hm5_pkg::ST_CHECKLAST;
            if (kc_ff < 8'(MAX_KEY_BYTES)) begin
               if (kc_ff < 8'(hm5_pkg::BLOCK_BYTES)) begin
                  mem_we    = 1'b1;
                  mem_waddr = {1'b0, kc_ff[5:0]};
                  kc_in     = kc_ff + 8'd1;
               end else if (kc_ff == 8'(hm5_pkg::BLOCK_BYTES)) begin
                  // The first full key block is hashed before the key spills.
                  job_start = 1'b1;
                  mode_in   = hm5_pkg::MODE_KEY_RAW;
                  dst_in    = hm5_pkg::DST_CHAIN;
                  ret_in    = hm5_pkg::ST_KEYBUF;
                  state_in  = hm5_pkg::ST_WAIT;
               end else begin
                  state_in = hm5_pkg::ST_KEYBUF;
               end
            end
         end
         hm5_pkg::ST_KEYBUF: begin
            mem_we    = 1'b1;
            mem_waddr = {1'b1, kc_ff[5:0]};
            kc_in     = kc_ff + 8'd1;
            state_in  = hm5_pkg::ST_CHECKLAST;
            if (kc_ff[5:0] == 6'd63) begin
               job_start = 1'b1;
               mode_in   = hm5_pkg::MODE_BUF;
               rem_in    = 7'd64;
               put80_in  = 1'b0;
               addlen_in = 1'b0;
               dst_in    = hm5_pkg::DST_CHAIN;
               ret_in    = hm5_pkg::ST_CHECKLAST;
               state_in  = hm5_pkg::ST_WAIT;
            end
         end
         hm5_pkg::ST_CHECKLAST: begin
            if (last_ff) begin
               cret_in  = hm5_pkg::ST_IDLE;
               state_in = hm5_pkg::ST_CLOSE;
            end else begin
               state_in = hm5_pkg::ST_IDLE;
            end
         end
         hm5_pkg::ST_CLOSE: begin
            if (kc_ff > 8'(hm5_pkg::BLOCK_BYTES)) begin
               rem_in   = {1'b0, kc_ff[5:0]};
               len_in   = {1'b0, kc_ff, 3'b000};
               fkey_in  = 1'b1;
               state_in = hm5_pkg::ST_FIN_A;
            end else begin
               phase_in = hm5_pkg::PH_KEY_READY;
               state_in = cret_ff;
            end
         end
         hm5_pkg::ST_FIN_A: begin
            job_start = 1'b1;
            mode_in   = hm5_pkg::MODE_BUF;
            put80_in  = 1'b1;
            addlen_in = (rem_ff < 7'd56);
            dst_in    = hm5_pkg::DST_CHAIN;
            ret_in    = (rem_ff < 7'd56) ? hm5_pkg::ST_FIN_DONE : hm5_pkg::ST_FIN_B;
            state_in  = hm5_pkg::ST_WAIT;
         end
         hm5_pkg::ST_FIN_B: begin
            job_start = 1'b1;
            mode_in   = hm5_pkg::MODE_BUF;
            rem_in    = 7'd0;
            put80_in  = 1'b0;
            addlen_in = 1'b1;
            dst_in    = hm5_pkg::DST_CHAIN;
            ret_in    = hm5_pkg::ST_FIN_DONE;
            state_in  = hm5_pkg::ST_WAIT;
         end
         hm5_pkg::ST_FIN_DONE: begin
            if (fkey_ff) begin
               kdig_in   = chain_ff;
               hashed_in = 1'b1;
               phase_in  = hm5_pkg::PH_KEY_READY;
               state_in  = cret_ff;
            end else begin
               state_in = hm5_pkg::ST_OUTER;
            end
         end
         hm5_pkg::ST_MSG: begin
            if (phase_ff == hm5_pkg::PH_AWAIT_KEY || phase_ff == hm5_pkg::PH_KEY) begin
               cret_in  = hm5_pkg::ST_MSGPH;
               state_in = hm5_pkg::ST_CLOSE;
            end else begin
               state_in = hm5_pkg::ST_MSGPH;
            end
         end
         hm5_pkg::ST_MSGPH: begin
            if (phase_ff == hm5_pkg::PH_KEY_READY) begin
               job_start = 1'b1;
               core_init = hm5_pkg::MD5_IV;
               mode_in   = hm5_pkg::MODE_KEY_IPAD;
               dst_in    = hm5_pkg::DST_CHAIN;
               ret_in    = hm5_pkg::ST_OPAD;
               state_in  = hm5_pkg::ST_WAIT;
            end else begin
               state_in = hm5_pkg::ST_MSGWR;
            end
         end
         hm5_pkg::ST_OPAD: begin
            job_start = 1'b1;
            core_init = hm5_pkg::MD5_IV;
            mode_in   = hm5_pkg::MODE_KEY_OPAD;
            dst_in    = hm5_pkg::DST_OUTER;
            ret_in    = hm5_pkg::ST_MSGWR;
            mc_in     = 8'd0;
            phase_in  = hm5_pkg::PH_MSG;
            state_in  = hm5_pkg::ST_WAIT;
         end
         hm5_pkg::ST_MSGWR: begin
            state_in = hm5_pkg::ST_MSGLAST;
            if (mc_ff < 8'(MAX_MESSAGE_BYTES)) begin
               mem_we    = 1'b1;
               mem_waddr = {1'b1, mc_ff[5:0]};
               mc_in     = mc_ff + 8'd1;
               if (mc_ff[5:0] == 6'd63) begin
                  job_start = 1'b1;
                  mode_in   = hm5_pkg::MODE_BUF;
                  rem_in    = 7'd64;
                  put80_in  = 1'b0;
                  addlen_in = 1'b0;
                  dst_in    = hm5_pkg::DST_CHAIN;
                  ret_in    = hm5_pkg::ST_MSGLAST;
                  state_in  = hm5_pkg::ST_WAIT;
               end
            end
         end
         hm5_pkg::ST_MSGLAST: begin
            if (last_ff) begin
               rem_in   = {1'b0, mc_ff[5:0]};
               len_in   = {mlen, 3'b000};
               fkey_in  = 1'b0;
               state_in = hm5_pkg::ST_FIN_A;
            end else begin
               state_in = hm5_pkg::ST_IDLE;
            end
         end
         hm5_pkg::ST_OUTER: begin
            job_start = 1'b1;
            core_init = outer_ff;
            mode_in   = hm5_pkg::MODE_OUTER;
            dst_in    = hm5_pkg::DST_RESULT;
            ret_in    = hm5_pkg::ST_EMIT;
            state_in  = hm5_pkg::ST_WAIT;
         end
         hm5_pkg::ST_EMIT: begin
            // Waits only if the previous digest has not been fully taken.
            if (cnt_ff == 2'd0) begin
               olo_in    = rslt_ff[63:0];
               ohi_in    = rslt_ff[127:64];
               omatch_in = (rslt_ff == {thi_ff, tlo_ff});
               cnt_in    = 2'd2;
               phase_in  = hm5_pkg::PH_KEY_READY;
               state_in  = hm5_pkg::ST_IDLE;
            end
         end
         hm5_pkg::ST_WAIT: begin
            if (core_done) begin
               case (dst_ff)
                  hm5_pkg::DST_CHAIN: chain_in = core_digest;
                  hm5_pkg::DST_OUTER: outer_in = core_digest;
                  default:            rslt_in  = core_digest;
               endcase
               state_in = ret_ff;
            end
         end
         default: state_in = hm5_pkg::ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire
